### sv/pnt_pkg.sv
package pnt_pkg;

    localparam int unsigned TableEntriesDefault = 16;

    localparam logic signed [7:0] RssiThresholdReset = -8'sd65;
    localparam logic [3:0]        LeaveLimitReset    = 4'd3;
    localparam logic [15:0]       TimeoutReset       = 16'd30;

    // Configuration register indexes.
    localparam logic [1:0] RegRssiThreshold = 2'd0;
    localparam logic [1:0] RegLeaveLimit    = 2'd1;
    localparam logic [1:0] RegTimeout       = 2'd2;

    // Commands.
    localparam logic CmdBeacon = 1'b0;
    localparam logic CmdTick   = 1'b1;

    // Event codes.
    localparam logic [1:0] EvNone   = 2'd0;
    localparam logic [1:0] EvDetect = 2'd1;
    localparam logic [1:0] EvLeave  = 2'd2;

    localparam logic [3:0] WeakMax = 4'd15;

    typedef struct packed {
        logic        command;
        logic [31:0] sender_id;
        logic signed [7:0] rssi;
        logic [31:0] now_seconds;
    } t_request;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [31:0] neighbor_id;
        logic        last;
    } t_result;

    // Scan token handed from cell to cell during a request.
    typedef struct packed {
        logic        active;     // token is in this cell
        logic        found;      // sender already matched in an earlier cell
    } t_token;

    // What a cell reports in the cycle that it holds the token.
    typedef struct packed {
        logic        emit;
        logic [31:0] neighbor_id;
    } t_cell_out;

endpackage

### sv/pnt_cell.sv
// One table slot. When the scan token sits here, the slot checks the current
// request and updates itself; the token moves to the next cell next cycle.
module pnt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,      // first cycle of a new request
    input  pnt_pkg::t_token   i_token,
    input  pnt_pkg::t_request i_req,
    input  logic signed [7:0] i_rssi_threshold,
    input  logic [3:0]        i_leave_limit,
    input  logic [15:0]       i_timeout,
    input  logic              i_claim,      // this slot takes the new sender
    output pnt_pkg::t_token   o_token,
    output pnt_pkg::t_cell_out o_out,
    output logic              o_free
);

    logic [31:0] r_id;
    logic [31:0] r_seen;
    logic [3:0]  r_weak;

    logic        n_match;
    logic        is_weak;
    logic [3:0]  weak_inc;
    logic        expired;
    logic [32:0] age;

    pnt_pkg::t_cell_out n_out;

    // Slot evaluation for the request at the token.
    always_comb begin
        n_match  = i_token.active && (i_req.command == pnt_pkg::CmdBeacon) &&
                   (r_id == i_req.sender_id) && (r_id != 32'd0);
        is_weak  = i_req.rssi < i_rssi_threshold;
        weak_inc = (r_weak < pnt_pkg::WeakMax) ? r_weak + 4'd1 : r_weak;
        age      = {1'b0, i_req.now_seconds} - {1'b0, r_seen};
        expired  = (r_id != 32'd0) && !age[32] && (age[31:0] >= {16'd0, i_timeout});
        n_out             = '0;
        n_out.neighbor_id = r_id;
        if (i_token.active) begin
            if (i_req.command == pnt_pkg::CmdTick) begin
                n_out.emit = expired;
            end else begin
                n_out.emit = n_match && is_weak && (weak_inc >= i_leave_limit);
            end
        end
        o_out  = n_out;
        o_free = (r_id == 32'd0);
    end

    // Token forwarding: the match flag is collected along the row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            o_token <= '0;
        end else begin
            o_token.active <= i_token.active;
            o_token.found  <= i_token.found | n_match;
        end
    end

    // Slot state. A claim comes from the sequencer once the whole row is known.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id   <= '0;
            r_seen <= '0;
            r_weak <= '0;
        end else if (n_out.emit) begin
            r_id   <= '0;
            r_seen <= '0;
            r_weak <= '0;
        end else if (n_match) begin
            if (is_weak) begin
                r_weak <= weak_inc;
            end else begin
                r_seen <= i_req.now_seconds;
                r_weak <= '0;
            end
        end else if (i_claim) begin
            r_id   <= i_req.sender_id;
            r_seen <= i_req.now_seconds;
            r_weak <= '0;
        end
    end

endmodule

### sv/pnt_ctrl.sv
// Sequencer: launches the token, runs the claim step, and drives results.
module pnt_ctrl #(
    parameter int unsigned TableEntries = pnt_pkg::TableEntriesDefault
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  pnt_pkg::t_request       i_req,
    input  logic signed [7:0]       i_rssi_threshold,
    input  pnt_pkg::t_token         i_tail,      // token leaving the last cell
    input  pnt_pkg::t_cell_out      i_cell_out [TableEntries],
    input  logic [TableEntries-1:0] i_free,
    output logic                    o_busy,
    output logic                    o_clear,
    output pnt_pkg::t_token         o_head,
    output logic [TableEntries-1:0] o_claim,
    output pnt_pkg::t_request       o_req,
    output logic                    o_valid,
    output pnt_pkg::t_result        o_result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CLAIM
    } t_state;

    localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;

    t_state                r_state;
    logic [IdxW-1:0]       r_pos;
    logic                  r_head;
    logic                  r_pend;      // a leave is held back to learn "last"
    logic [31:0]           r_pend_id;
    pnt_pkg::t_request     r_req;
    logic                  r_valid;
    pnt_pkg::t_result      r_result;

    pnt_pkg::t_cell_out    cur;
    logic                  at_end;
    logic                  detect;
    logic [TableEntries-1:0] first_free;

    // Current cell, end of row, and the lowest free slot for a new sender.
    always_comb begin
        cur    = i_cell_out[r_pos];
        at_end = (r_pos == IdxW'(TableEntries - 1));
        first_free = '0;
        for (int k = TableEntries - 1; k >= 0; k--) begin
            if (i_free[k]) begin
                first_free    = '0;
                first_free[k] = 1'b1;
            end
        end
        detect = (r_state == ST_CLAIM) && (r_req.command == pnt_pkg::CmdBeacon) &&
                 (r_req.sender_id != 32'd0) && !i_tail.found &&
                 !(r_req.rssi < i_rssi_threshold) && (|i_free);
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_clear  = i_start && !o_busy;
    assign o_head   = '{active: r_head, found: 1'b0};
    assign o_req    = r_req;
    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_claim  = detect ? first_free : '0;

    // State and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_head  <= 1'b0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_head  <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_req   <= i_req;
                        r_pos   <= '0;
                        r_pend  <= 1'b0;
                        r_head  <= 1'b1;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (cur.emit) begin
                        if (r_pend) begin
                            r_valid  <= 1'b1;
                            r_result <= '{event_res: pnt_pkg::EvLeave,
                                          neighbor_id: r_pend_id, last: 1'b0};
                        end
                        r_pend    <= 1'b1;
                        r_pend_id <= cur.neighbor_id;
                    end
                    if (at_end) begin
                        r_state <= ST_CLAIM;
                    end else begin
                        r_pos <= r_pos + IdxW'(1);
                    end
                end
                ST_CLAIM: begin
                    r_state <= ST_IDLE;
                    if (r_pend) begin
                        r_valid  <= 1'b1;
                        r_result <= '{event_res: pnt_pkg::EvLeave,
                                      neighbor_id: r_pend_id, last: 1'b1};
                    end else if (r_req.command == pnt_pkg::CmdTick) begin
                        r_valid  <= 1'b1;
                        r_result <= '{event_res: pnt_pkg::EvNone,
                                      neighbor_id: 32'd0, last: 1'b1};
                    end else if (detect) begin
                        r_valid  <= 1'b1;
                        r_result <= '{event_res: pnt_pkg::EvDetect,
                                      neighbor_id: r_req.sender_id, last: 1'b1};
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

### sv/proximity_neighbor_table_top.sv
// Results: the last result of a request is registered in the claim step after the
// token walk; leaves found by a tick come out during the scan, each held back to
// learn whether it is the last, and the last one comes out with the claim step.
// Requests: one at a time, through the token walk over the slot cells, the claim step and idle.
// Reset: synchronous, active low; clears all slots and loads the register
// defaults. The receiver cannot stall the result strobe.
module proximity_neighbor_table_top #(
    parameter int unsigned TABLE_ENTRIES = pnt_pkg::TableEntriesDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pnt_pkg::t_request i_req,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output logic              o_valid,
    output pnt_pkg::t_result  o_result
);

    logic signed [7:0] r_rssi_threshold;
    logic [3:0]        r_leave_limit;
    logic [15:0]       r_timeout;

    pnt_pkg::t_token    token [TABLE_ENTRIES+1];
    pnt_pkg::t_cell_out cell_out [TABLE_ENTRIES];
    pnt_pkg::t_request  req;
    logic [TABLE_ENTRIES-1:0] claim;
    logic [TABLE_ENTRIES-1:0] free_slot;
    logic clear;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rssi_threshold <= pnt_pkg::RssiThresholdReset;
            r_leave_limit    <= pnt_pkg::LeaveLimitReset;
            r_timeout        <= pnt_pkg::TimeoutReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pnt_pkg::RegRssiThreshold: r_rssi_threshold <= i_cfg_data[7:0];
                pnt_pkg::RegLeaveLimit:    r_leave_limit    <= i_cfg_data[3:0];
                pnt_pkg::RegTimeout:       r_timeout        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Row of slot cells; each hands the token to its neighbor.
    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            pnt_cell u_cell (
                .i_clk           (i_clk),
                .i_rst_n         (i_rst_n),
                .i_clear         (clear),
                .i_token         (token[g]),
                .i_req           (req),
                .i_rssi_threshold(r_rssi_threshold),
                .i_leave_limit   (r_leave_limit),
                .i_timeout       (r_timeout),
                .i_claim         (claim[g]),
                .o_token         (token[g+1]),
                .o_out           (cell_out[g]),
                .o_free          (free_slot[g])
            );
        end
    endgenerate

    pnt_ctrl #(.TableEntries(TABLE_ENTRIES)) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_req           (i_req),
        .i_rssi_threshold(r_rssi_threshold),
        .i_tail          (token[TABLE_ENTRIES]),
        .i_cell_out      (cell_out),
        .i_free          (free_slot),
        .o_busy          (busy),
        .o_clear         (clear),
        .o_head          (token[0]),
        .o_claim         (claim),
        .o_req           (req),
        .o_valid         (o_valid),
        .o_result        (o_result)
    );

    // A result only appears while a request is in progress or just finished.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("result without request");

    // The last flag is seen once busy drops.
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last) |-> !busy) else $error("last while busy");

endmodule

### tb/proximity_neighbor_table_top_test.sv
`timescale 1ns / 100ps

module proximity_neighbor_table_top_test;

    localparam int Entries    = pnt_pkg::TableEntriesDefault;
    localparam int IdleLimit  = 2000;
    localparam int DrainWait  = 3 * (Entries + 2);

    typedef struct packed {
        logic       we;
        logic [1:0] index;
        logic [15:0] data;
    } t_cfg_write;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    pnt_pkg::t_request i_req = '0;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_index = '0;
    logic [15:0]       i_cfg_data = '0;
    logic              o_valid;
    pnt_pkg::t_result  o_result;

    // Predicted table contents and registers.
    logic [31:0]        tbl_id [Entries];
    logic [31:0]        tbl_seen [Entries];
    logic [3:0]         tbl_weak [Entries];
    logic signed [7:0]  thr_reg;
    logic [3:0]         limit_reg;
    logic [15:0]        timeout_reg;

    pnt_pkg::t_request request_queue [$];
    pnt_pkg::t_result  event_queue [$];
    int         sender_idle_pct = 24;
    int         failures = 0;
    int         idle_cycles = 0;
    int         n_requests = 0;
    int         n_events = 0;
    int         n_leaves = 0;
    int         n_detects = 0;
    t_cfg_write cfg_pending = '0;
    logic [31:0] id_pool [8];

    proximity_neighbor_table_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    always #2 i_clk = ~i_clk;

    // Push one predicted event onto the expected list.
    function automatic void push_event(logic [1:0] ev, logic [31:0] id, logic lst);
        pnt_pkg::t_result r;
        r.event_res = ev;
        r.neighbor_id = id;
        r.last = lst;
        event_queue.push_back(r);
    endfunction

    // Predict the events of one accepted request and update the table.
    function automatic void predict_neighbor_events(pnt_pkg::t_request rq);
        int k;
        int hit;
        int cnt;
        pnt_pkg::t_result r;
        hit = -1;
        cnt = 0;
        if (rq.command == pnt_pkg::CmdTick) begin
            for (k = 0; k < Entries; k++) begin
                if (tbl_id[k] != 32'd0 && rq.now_seconds >= tbl_seen[k] &&
                    (rq.now_seconds - tbl_seen[k]) >= {16'd0, timeout_reg}) begin
                    push_event(pnt_pkg::EvLeave, tbl_id[k], 1'b0);
                    cnt++;
                    tbl_id[k] = '0; tbl_seen[k] = '0; tbl_weak[k] = '0;
                end
            end
            if (cnt == 0) push_event(pnt_pkg::EvNone, 32'd0, 1'b0);
            r = event_queue.pop_back();
            r.last = 1'b1;
            event_queue.push_back(r);
            return;
        end
        if (rq.sender_id == 32'd0) return;
        for (k = Entries - 1; k >= 0; k--)
            if (tbl_id[k] == rq.sender_id) hit = k;
        if (rq.rssi < thr_reg) begin
            if (hit >= 0) begin
                if (tbl_weak[hit] < pnt_pkg::WeakMax) tbl_weak[hit]++;
                if (tbl_weak[hit] >= limit_reg) begin
                    tbl_id[hit] = '0; tbl_seen[hit] = '0; tbl_weak[hit] = '0;
                    push_event(pnt_pkg::EvLeave, rq.sender_id, 1'b1);
                end
            end
            return;
        end
        if (hit >= 0) begin
            tbl_seen[hit] = rq.now_seconds;
            tbl_weak[hit] = '0;
            return;
        end
        for (k = 0; k < Entries; k++) begin
            if (tbl_id[k] == 32'd0) begin
                tbl_id[k] = rq.sender_id;
                tbl_seen[k] = rq.now_seconds;
                tbl_weak[k] = '0;
                push_event(pnt_pkg::EvDetect, rq.sender_id, 1'b1);
                return;
            end
        end
    endfunction

    // Driver: present queued requests with random gaps, and register writes.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                predict_neighbor_events(i_req);
                n_requests++;
            end
            if (request_queue.size() != 0 && !(start && busy) &&
                $urandom_range(99) >= sender_idle_pct) begin
                start <= 1'b1;
                i_req <= request_queue.pop_front();
            end else if (!(start && busy)) begin
                start <= 1'b0;
            end
        end
        i_cfg_we <= cfg_pending.we;
        i_cfg_index <= cfg_pending.index;
        i_cfg_data <= cfg_pending.data;
        cfg_pending.we = 1'b0;
    end

    // Monitor: compare every strobed event with the oldest prediction.
    always @(posedge i_clk) begin
        pnt_pkg::t_result exp_r;
        if (i_rst_n && o_valid) begin
            n_events++;
            if (event_queue.size() == 0) begin
                $error("unexpected event %0d id %0h", o_result.event_res,
                       o_result.neighbor_id);
                failures++;
            end else begin
                exp_r = event_queue.pop_front();
                if (exp_r.event_res == pnt_pkg::EvLeave) n_leaves++;
                if (exp_r.event_res == pnt_pkg::EvDetect) n_detects++;
                if (o_result.event_res !== exp_r.event_res) begin
                    $error("event_res expected %0d actual %0d", exp_r.event_res,
                           o_result.event_res);
                    failures++;
                end
                if (o_result.neighbor_id !== exp_r.neighbor_id) begin
                    $error("neighbor_id expected %0h actual %0h",
                           exp_r.neighbor_id, o_result.neighbor_id);
                    failures++;
                end
                if (o_result.last !== exp_r.last) begin
                    $error("last expected %0b actual %0b", exp_r.last,
                           o_result.last);
                    failures++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request or event.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("[proximity_neighbor_table_top] ERROR");
            $finish;
        end
    end

    // Write one register through the driver's registered write port and track it in the prediction.
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        cfg_pending = '{we: 1'b1, index: idx, data: val};
        @(posedge i_clk);
        @(negedge i_clk);
        case (idx)
            pnt_pkg::RegRssiThreshold: thr_reg = val[7:0];
            pnt_pkg::RegLeaveLimit:    limit_reg = val[3:0];
            pnt_pkg::RegTimeout:       timeout_reg = val;
            default: ;
        endcase
    endtask

    // Wait until every queued request is accepted and every event has come.
    task automatic drain();
        while (request_queue.size() != 0 || start || event_queue.size() != 0)
            @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
    endtask

    function automatic pnt_pkg::t_request make_req(logic cmd, logic [31:0] id,
                                                   logic [7:0] rs, logic [31:0] now);
        pnt_pkg::t_request rq;
        rq.command = cmd;
        rq.sender_id = id;
        rq.rssi = rs;
        rq.now_seconds = now;
        return rq;
    endfunction

    // Random request mix biased toward a small pool of ids.
    task automatic queue_random(int count, logic [31:0] base_now);
        logic [31:0] now;
        int sel;
        now = base_now;
        for (int n = 0; n < count; n++) begin
            now = now + $urandom_range(8);
            sel = $urandom_range(99);
            if (sel < 12)
                request_queue.push_back(make_req(pnt_pkg::CmdTick, 32'd0, 8'($urandom),
                    ($urandom_range(9) == 0) ? $urandom : now));
            else if (sel < 80)
                request_queue.push_back(make_req(pnt_pkg::CmdBeacon,
                    id_pool[$urandom_range(7)], 8'($urandom), now));
            else if (sel < 85)
                request_queue.push_back(make_req(pnt_pkg::CmdBeacon, 32'd0,
                    8'($urandom), now));
            else
                request_queue.push_back(make_req(pnt_pkg::CmdBeacon, $urandom,
                    8'($urandom), ($urandom_range(4) == 0) ? $urandom : now));
        end
    endtask

    initial begin
        for (int k = 0; k < Entries; k++) begin
            tbl_id[k] = '0; tbl_seen[k] = '0; tbl_weak[k] = '0;
        end
        thr_reg = pnt_pkg::RssiThresholdReset;
        limit_reg = pnt_pkg::LeaveLimitReset;
        timeout_reg = pnt_pkg::TimeoutReset;
        for (int k = 0; k < 8; k++) id_pool[k] = $urandom | 32'h1;
        id_pool[0] = 32'hFFFF_FFFF;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with reset register values.
        request_queue.push_back(make_req(pnt_pkg::CmdTick, 32'd0, 8'sd0, 32'd0));
        request_queue.push_back(make_req(pnt_pkg::CmdBeacon, 32'd0, 8'sd127, 32'd5));
        request_queue.push_back(make_req(pnt_pkg::CmdBeacon, 32'h55, -8'sd128, 32'd5));
        request_queue.push_back(make_req(pnt_pkg::CmdBeacon, 32'hFFFF_FFFF, 8'sd127,
                                         32'd1));
        request_queue.push_back(make_req(pnt_pkg::CmdBeacon, 32'h1, -8'sd65, 32'd2));
        request_queue.push_back(make_req(pnt_pkg::CmdBeacon, 32'h1, -8'sd66, 32'd3));
        request_queue.push_back(make_req(pnt_pkg::CmdBeacon, 32'h1, -8'sd66, 32'd3));
        request_queue.push_back(make_req(pnt_pkg::CmdBeacon, 32'h1, -8'sd66, 32'd3));
        for (int k = 2; k < 19; k++)
            request_queue.push_back(make_req(pnt_pkg::CmdBeacon, 32'(k), 8'sd0,
                                             32'hFFFF_FFF0));
        request_queue.push_back(make_req(pnt_pkg::CmdTick, 32'd0, 8'sd0, 32'd31));
        request_queue.push_back(make_req(pnt_pkg::CmdTick, 32'd0, 8'sd0, 32'hFFFF_FFFF));
        drain();

        // Extreme register settings: limit 0 and 15, timeout 0 and max, threshold ends.
        write_reg(pnt_pkg::RegLeaveLimit, 16'd0);
        write_reg(pnt_pkg::RegTimeout, 16'd0);
        write_reg(pnt_pkg::RegRssiThreshold, 16'h0080);
        request_queue.push_back(make_req(pnt_pkg::CmdBeacon, 32'h77, -8'sd128, 32'd100));
        request_queue.push_back(make_req(pnt_pkg::CmdBeacon, 32'h78, -8'sd1, 32'd200));
        request_queue.push_back(make_req(pnt_pkg::CmdTick, 32'd0, 8'sd0, 32'd150));
        request_queue.push_back(make_req(pnt_pkg::CmdTick, 32'd0, 8'sd0, 32'd200));
        drain();
        write_reg(pnt_pkg::RegRssiThreshold, 16'h007F);
        write_reg(pnt_pkg::RegLeaveLimit, 16'd15);
        write_reg(pnt_pkg::RegTimeout, 16'hFFFF);
        request_queue.push_back(make_req(pnt_pkg::CmdBeacon, 32'h79, 8'sd127, 32'd10));
        for (int k = 0; k < 16; k++)
            request_queue.push_back(make_req(pnt_pkg::CmdBeacon, 32'h79, 8'sd126,
                                             32'd10));
        request_queue.push_back(make_req(pnt_pkg::CmdTick, 32'd0, 8'sd0, 32'd65545));
        drain();

        // Random phases with differing settings and idling.
        sender_idle_pct = 24;
        write_reg(pnt_pkg::RegRssiThreshold, 16'hFFBF);
        write_reg(pnt_pkg::RegLeaveLimit, 16'd3);
        write_reg(pnt_pkg::RegTimeout, 16'd20);
        queue_random(85, 32'd1000);
        drain();
        sender_idle_pct = 76;
        write_reg(pnt_pkg::RegRssiThreshold, 16'($urandom));
        write_reg(pnt_pkg::RegLeaveLimit, 16'd1);
        write_reg(pnt_pkg::RegTimeout, 16'd5);
        queue_random(85, 32'h8000_0000);
        drain();
        sender_idle_pct = 0;
        write_reg(pnt_pkg::RegRssiThreshold, 16'h0000);
        write_reg(pnt_pkg::RegLeaveLimit, 16'd2);
        write_reg(pnt_pkg::RegTimeout, 16'd40);
        queue_random(85, 32'hFFFF_FF00);
        drain();

        $display("Covered %0d requests and %0d events (%0d detects, %0d leaves).",
                 n_requests, n_events, n_detects, n_leaves);
        if (failures == 0) begin
            $display("[proximity_neighbor_table_top] OK");
        end else begin
            $display("[proximity_neighbor_table_top] ERROR");
        end
        $finish;
    end

endmodule
